@@ hdl/rbpd_pkg.sv @@
// Shared types and constants for the raw block pixel decompressor.
package rbpd_pkg;

   localparam int unsigned PIXELS_PER_BLOCK = 16;
   localparam int unsigned PIX_W            = 11;
   localparam int unsigned CODE_W           = 7;
   localparam int unsigned CODES_W          = 98;
   localparam int unsigned SHIFT_W          = 3;
   localparam int unsigned SHIFT_LIMIT      = 4;

   localparam logic [PIX_W-1:0] RANGE_BASE   = 11'h080;
   localparam logic [PIX_W-1:0] PIXEL_CEIL   = 11'h7ff;
   localparam logic [3:0]       LAST_INDEX   = 4'hf;

   // Header fields and the packed codes of one block, as decoded by the front end.
   typedef struct packed {
      logic [CODES_W-1:0] codes;
      logic [PIX_W-1:0]   max_val;
      logic [PIX_W-1:0]   min_val;
      logic [3:0]         max_pos;
      logic [3:0]         min_pos;
      logic [SHIFT_W-1:0] shift;
      logic               error;
   } rbpd_desc_type;

   // Queue status seen by both the front and the back end.
   typedef struct packed {
      logic full;
      logic not_empty;
   } rbpd_qstat_type;

endpackage

@@ hdl/rbpd_if.sv @@
// Handshake interfaces for the compressed block words and the pixel words.
interface rbpd_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_low;
   logic [63:0] block_high;

   modport source (output valid, output block_low, output block_high, input ready);
   modport sink   (input valid, input block_low, input block_high, output ready);
endinterface

interface rbpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] pixel_value;
   logic [3:0]  pixel_index;
   logic        last_pixel;
   logic        block_error;

   modport source (output valid, output pixel_value, output pixel_index,
                   output last_pixel, output block_error, input ready);
   modport sink   (input valid, input pixel_value, input pixel_index,
                   input last_pixel, input block_error, output ready);
endinterface

@@ hdl/rbpd_front.sv @@
// Front end: accepts a compressed block and decodes its header into a descriptor.
module rbpd_front (
   rbpd_req_if.sink               req_bus,
   input  rbpd_pkg::rbpd_qstat_type q_stat,
   output logic                    q_push,
   output rbpd_pkg::rbpd_desc_type q_data
);
   import rbpd_pkg::*;

   logic [127:0]     block;
   logic [PIX_W:0]   diff;
   logic [SHIFT_W-1:0] shift;

   assign block = {req_bus.block_high, req_bus.block_low};

   // The max-min difference is signed; a negative range keeps the shift at zero.
   assign diff = {1'b0, block[10:0]} - {1'b0, block[21:11]};

   always_comb begin
      shift = '0;
      if (!diff[PIX_W]) begin
         for (int k = 0; k < SHIFT_LIMIT; k++) begin
            if (diff[PIX_W-1:0] >= (RANGE_BASE << k)) begin
               shift = shift + SHIFT_W'(1);
            end
         end
      end
   end

   always_comb begin
      q_data.codes   = block[127:30];
      q_data.max_val = block[10:0];
      q_data.min_val = block[21:11];
      q_data.max_pos = block[25:22];
      q_data.min_pos = block[29:26];
      q_data.shift   = shift;
      q_data.error   = (block[25:22] == block[29:26]);
   end

   assign req_bus.ready = !q_stat.full;
   assign q_push        = req_bus.valid && !q_stat.full;

endmodule

@@ hdl/rbpd_queue.sv @@
// Short descriptor queue between the front and the back end.
module rbpd_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rbpd_pkg::rbpd_desc_type push_data,
   input  logic                    pop,
   output rbpd_pkg::rbpd_desc_type pop_data,
   output rbpd_pkg::rbpd_qstat_type stat
);
   import rbpd_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rbpd_desc_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      nxt = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
      return nxt;
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data       = slot_ff[rd_ptr_ff];
   assign stat.full      = (count_ff == CNT_W'(DEPTH));
   assign stat.not_empty = (count_ff != '0);

endmodule

@@ hdl/rbpd_back.sv @@
// Back end: expands one descriptor into sixteen pixel words, or one error word.
module rbpd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  rbpd_pkg::rbpd_qstat_type q_stat,
   input  rbpd_pkg::rbpd_desc_type  q_data,
   output logic                     q_pop,
   rbpd_rsp_if.source               rsp_bus
);
   import rbpd_pkg::*;

   rbpd_desc_type  cur_ff, cur_in;
   logic           active_ff, active_in;
   logic [3:0]     idx_ff, idx_in;
   logic           out_valid_ff, out_valid_in;
   logic [11:0]    out_value_ff, out_value_in;
   logic [3:0]     out_index_ff, out_index_in;
   logic           out_last_ff, out_last_in;
   logic           out_error_ff, out_error_in;

   logic           advance, step, is_last, load;
   logic           hit_max, hit_min;
   logic [PIX_W:0] coded;
   logic [PIX_W-1:0] pix;

   assign advance = !out_valid_ff || rsp_bus.ready;
   assign step    = active_ff && advance;
   assign is_last = cur_ff.error || (idx_ff == LAST_INDEX);
   assign load    = q_stat.not_empty && (!active_ff || (step && is_last));
   assign q_pop   = load;

   assign hit_max = (idx_ff == cur_ff.max_pos);
   assign hit_min = (idx_ff == cur_ff.min_pos);

   // Seven-bit code scaled by the range shift, offset by min, clipped to 11 bits.
   assign coded = ({(PIX_W + 1 - CODE_W)'(0), cur_ff.codes[CODE_W-1:0]} << cur_ff.shift)
                  + {1'b0, cur_ff.min_val};

   always_comb begin
      if (hit_max) begin
         pix = cur_ff.max_val;
      end else if (hit_min) begin
         pix = cur_ff.min_val;
      end else if (coded[PIX_W]) begin
         pix = PIXEL_CEIL;
      end else begin
         pix = coded[PIX_W-1:0];
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_index_in = out_index_ff;
      out_last_in  = out_last_ff;
      out_error_in = out_error_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_value_in = cur_ff.error ? 12'h000 : {pix, 1'b0};
         out_index_in = cur_ff.error ? 4'h0 : idx_ff;
         out_last_in  = is_last;
         out_error_in = cur_ff.error;
      end else if (advance) begin
         out_valid_in = 1'b0;
      end

      cur_in    = cur_ff;
      idx_in    = idx_ff;
      active_in = active_ff;
      if (load) begin
         cur_in    = q_data;
         idx_in    = '0;
         active_in = 1'b1;
      end else if (step) begin
         if (is_last) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff + 4'd1;
            if (!hit_max && !hit_min) begin
               cur_in.codes = cur_ff.codes >> CODE_W;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff       <= cur_in;
      idx_ff       <= idx_in;
      out_value_ff <= out_value_in;
      out_index_ff <= out_index_in;
      out_last_ff  <= out_last_in;
      out_error_ff <= out_error_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.pixel_value = out_value_ff;
   assign rsp_bus.pixel_index = out_index_ff;
   assign rsp_bus.last_pixel  = out_last_ff;
   assign rsp_bus.block_error = out_error_ff;

endmodule

@@ hdl/raw_block_pixel_decompressor_top.sv @@
// Top level of the raw block pixel decompressor.
// Each request word carries one 128-bit compressed block (block_low is bits 63:0) that holds
// an 11-bit max, an 11-bit min, two 4-bit pixel positions and fourteen 7-bit codes. The
// block leaves as sixteen response words, one pixel each in order, with the 11-bit value
// doubled into pixel_value and last_pixel set on pixel fifteen. When the two positions are
// equal the block yields a single word with block_error and last_pixel set and zero value
// and index. A front end decodes the header and the range shift as the word is accepted and
// places a descriptor into a short queue (QUEUE_DEPTH entries); a back end expands the
// descriptor at one pixel per cycle, unless the output stalls, into a registered output
// stage. Under steady traffic the single pixel per cycle of the back end sets the block
// rate; an error block yields only one word. The request side keeps accepting words while
// the queue has room, so up to QUEUE_DEPTH blocks may wait behind the one being expanded.
// On its way out a block passes a queue slot, the descriptor register and the output register.
module raw_block_pixel_decompressor_top #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   rbpd_req_if.sink    req_bus,
   rbpd_rsp_if.source  rsp_bus
);
   import rbpd_pkg::*;

   rbpd_desc_type  push_data;
   rbpd_desc_type  pop_data;
   rbpd_qstat_type q_stat;
   logic           q_push;
   logic           q_pop;

   // Header decode and range shift, written straight into the queue.
   rbpd_front u_front (
      .req_bus (req_bus),
      .q_stat  (q_stat),
      .q_push  (q_push),
      .q_data  (push_data)
   );

   // Decouples acceptance from pixel expansion.
   rbpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .stat      (q_stat)
   );

   // Pixel sequencer with its output register.
   rbpd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_stat  (q_stat),
      .q_data  (pop_data),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

   // The queue is never written while full nor read while empty.
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("descriptor pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_stat.not_empty)
      else $error("descriptor popped from an empty queue");

   // An error word stands alone: last, index zero and value zero.
   a_error_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.block_error) |->
         (rsp_bus.last_pixel && rsp_bus.pixel_index == 4'h0 && rsp_bus.pixel_value == 12'h000))
      else $error("malformed error word");

   // A regular block ends exactly on pixel fifteen.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.block_error) |->
         (rsp_bus.last_pixel == (rsp_bus.pixel_index == LAST_INDEX)))
      else $error("last_pixel does not match pixel fifteen");

endmodule
